// ----- src/utf16_to_utf8_transcoder_core_assert.svh -----
// Assertion macros for the UTF-16 to UTF-8 transcoder checker.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef UTF16_TO_UTF8_TRANSCODER_CORE_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define U16U8_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u16u8 same-cycle check failed");

// next-cycle implication, disabled while in reset
`define U16U8_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u16u8 next-cycle check failed");

`endif

// ----- src/u16u8_pkg.sv -----
// Package for the UTF-16 to UTF-8 transcoder: widths, code constants and
// the single-code-point encoder. No dependencies.
`timescale 1ns / 1ps

package u16u8_pkg;

	localparam int UNIT_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int LIMIT_W = 9;
	localparam int CNT_W   = 3;   // up to six bytes per transaction
	localparam int BUF_D   = 6;

	localparam logic [LIMIT_W-1:0] MAX_UNITS_RST = 9'd63;

	localparam logic [UNIT_W-1:0] HI_SURR_MIN = 16'hD800;
	localparam logic [UNIT_W-1:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [UNIT_W-1:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [UNIT_W-1:0] LO_SURR_MAX = 16'hDFFF;
	localparam logic [20:0]       SUPP_BASE   = 21'h10000;
	localparam logic [UNIT_W-1:0] TWO_BYTE_LIM = 16'h0800;
	localparam logic [UNIT_W-1:0] ONE_BYTE_LIM = 16'h0080;

	localparam logic [BYTE_W-1:0] LEAD2 = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3 = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4 = 8'hF0;
	localparam logic [BYTE_W-1:0] CONT  = 8'h80;
	localparam logic [5:0]        CONT_MASK = 6'h3F;

	typedef struct packed {
		logic [2:0][BYTE_W-1:0] b;    // b[0] goes out first
		logic [1:0]             len;  // 1..3
	} enc3_t;

	// encode a code point below 0x10000
	function automatic enc3_t enc3(input logic [UNIT_W-1:0] c);
		enc3_t r;
		r = '0;
		if (c < ONE_BYTE_LIM) begin
			r.b[0] = c[7:0];
			r.len  = 2'd1;
		end else if (c < TWO_BYTE_LIM) begin
			r.b[0] = LEAD2 | {3'b000, c[10:6]};
			r.b[1] = CONT | {2'b00, c[5:0] & CONT_MASK};
			r.len  = 2'd2;
		end else begin
			r.b[0] = LEAD3 | {4'h0, c[15:12]};
			r.b[1] = CONT | {2'b00, c[11:6]};
			r.b[2] = CONT | {2'b00, c[5:0] & CONT_MASK};
			r.len  = 2'd3;
		end
		return r;
	endfunction

endpackage

// ----- src/utf16_to_utf8_transcoder_core.sv -----
// UTF-16 to UTF-8 transcoder top level: string state, per-unit encoder and
// a six-byte result buffer. Depends on u16u8_pkg.
`timescale 1ns / 1ps

// channel   | signals                          | contents
// ----------+----------------------------------+--------------------------------------
// s_axis    | tvalid tready tdata[15:0] tlast  | code_unit, string_end
// m_axis    | tvalid tready tdata[7:0] tlast   | out_byte, run_last,
//           | tuser[1:0]                       | tuser = {string_done, byte_valid}
// cfg       | cfg_wr_en cfg_wr_data[8:0]       | max_units
//
// A unit is encoded in the cycle it is accepted; its bytes land in the result
// buffer, which sends one byte per cycle while m_axis_tready is high. A unit
// gives no bytes or 1 to 6 bytes. The next unit is taken in the cycle the
// last byte of the previous one is taken.
// arst_n clears string state, the buffer count and sets max_units to 63.
module utf16_to_utf8_transcoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
	input  logic        s_axis_tlast,   // string_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tlast,   // run_last
	output logic [1:0]  m_axis_tuser    // [0] byte_valid, [1] string_done
);

	localparam int UW = u16u8_pkg::UNIT_W;
	localparam int BW = u16u8_pkg::BYTE_W;
	localparam int LW = u16u8_pkg::LIMIT_W;
	localparam int CW = u16u8_pkg::CNT_W;
	localparam int BD = u16u8_pkg::BUF_D;

	logic [LW-1:0] max_units_q;
	logic [9:0]    held_high_q;
	logic          held_valid_q;
	logic [LW-1:0] unit_count_q;
	logic          stopped_q;

	logic [BD-1:0][BW-1:0] res_byte_s1;
	logic [CW-1:0]         res_cnt_s1;
	logic                  res_bv_s1;
	logic                  res_end_s1;

	logic                  take;
	logic                  pop;
	logic [UW-1:0]         u;
	logic                  drop;
	logic [LW-1:0]         cnt_inc;
	logic                  final_unit;
	logic                  is_high;
	logic                  is_low;
	logic                  pair;
	logic                  flush;
	logic                  emit_u;
	logic                  hold;
	u16u8_pkg::enc3_t      enc_u;
	u16u8_pkg::enc3_t      enc_f;
	logic [20:0]           supp;
	logic [BD-1:0][BW-1:0] nbytes;
	logic [CW-1:0]         ncnt;

	assign u    = s_axis_tdata;
	assign pop  = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (res_cnt_s1 == '0) || (res_cnt_s1 == CW'(1) && m_axis_tready);
	assign take = s_axis_tvalid && s_axis_tready;

	assign drop       = stopped_q || (unit_count_q >= max_units_q);
	assign cnt_inc    = unit_count_q + LW'(1);
	assign final_unit = s_axis_tlast || (cnt_inc == max_units_q);
	assign is_high    = (u >= u16u8_pkg::HI_SURR_MIN) && (u <= u16u8_pkg::HI_SURR_MAX);
	assign is_low     = (u >= u16u8_pkg::LO_SURR_MIN) && (u <= u16u8_pkg::LO_SURR_MAX);

	assign pair   = !drop && held_valid_q && is_low;
	assign flush  = held_valid_q && !pair;
	assign hold   = !drop && !pair && is_high && !final_unit;
	assign emit_u = !drop && !pair && !hold && (u != '0);

	assign enc_u = u16u8_pkg::enc3(u);
	assign enc_f = u16u8_pkg::enc3({6'b110110, held_high_q});
	assign supp  = u16u8_pkg::SUPP_BASE + {1'b0, held_high_q, u[9:0]};

	always_comb begin
		nbytes = '0;
		ncnt   = '0;
		if (pair) begin
			nbytes[0] = u16u8_pkg::LEAD4 | {5'b00000, supp[20:18]};
			nbytes[1] = u16u8_pkg::CONT | {2'b00, supp[17:12]};
			nbytes[2] = u16u8_pkg::CONT | {2'b00, supp[11:6]};
			nbytes[3] = u16u8_pkg::CONT | {2'b00, supp[5:0]};
			ncnt      = CW'(4);
		end else if (flush) begin
			nbytes[2:0] = enc_f.b;
			nbytes[5:3] = emit_u ? enc_u.b : '0;
			ncnt        = CW'(3) + (emit_u ? CW'(enc_u.len) : '0);
		end else begin
			// a bare done marker carries a zero byte
			nbytes[2:0] = emit_u ? enc_u.b : '0;
			ncnt        = emit_u ? CW'(enc_u.len) : '0;
		end
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_units_q  <= u16u8_pkg::MAX_UNITS_RST;
			held_high_q  <= '0;
			held_valid_q <= 1'b0;
			unit_count_q <= '0;
			stopped_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_units_q <= cfg_wr_data;
			end
			if (take) begin
				if (s_axis_tlast) begin
					held_high_q  <= '0;
					held_valid_q <= 1'b0;
					unit_count_q <= '0;
					stopped_q    <= 1'b0;
				end else begin
					held_valid_q <= hold;
					held_high_q  <= hold ? u[9:0] : 10'd0;
					if (!drop) begin
						unit_count_q <= cnt_inc;
						if (!pair && !is_high && u == '0) begin
							stopped_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	// result buffer: count is control, bytes are payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_s1 <= '0;
		end else if (take) begin
			// end of string with no bytes gives a bare done marker
			res_cnt_s1 <= (s_axis_tlast && ncnt == '0) ? CW'(1) : ncnt;
		end else if (pop) begin
			res_cnt_s1 <= res_cnt_s1 - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_byte_s1 <= nbytes;
			res_bv_s1   <= (ncnt != '0);
			res_end_s1  <= s_axis_tlast;
		end else if (pop) begin
			for (int i = 0; i < BD - 1; i++) begin
				res_byte_s1[i] <= res_byte_s1[i+1];
			end
			res_byte_s1[BD-1] <= '0;
		end
	end

	assign m_axis_tvalid = (res_cnt_s1 != '0);
	assign m_axis_tdata  = res_byte_s1[0];
	assign m_axis_tlast  = (res_cnt_s1 == CW'(1));
	assign m_axis_tuser  = {res_end_s1 && m_axis_tlast, res_bv_s1};

endmodule

// ----- src/u16u8_chk.sv -----
// Port-level checker for utf16_to_utf8_transcoder_core, bound to the top level.
// Depends on u16u8_pkg and utf16_to_utf8_transcoder_core_assert.svh.
`timescale 1ns / 1ps
`include "utf16_to_utf8_transcoder_core_assert.svh"

module u16u8_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [u16u8_pkg::BYTE_W-1:0]  m_axis_tdata,
	input logic                          m_axis_tlast,
	input logic [1:0]                    m_axis_tuser
);

	// a byteless result is only ever a done marker closing a string
	`U16U8_ASSERT_NOW(a_marker_closes, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && m_axis_tuser[1])

	// string done only on the last byte of a transaction
	`U16U8_ASSERT_NOW(a_done_is_last, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)

	// no new unit while more bytes of the current one are pending
	`U16U8_ASSERT_NOW(a_no_take_midrun, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

	// stalled output holds
	`U16U8_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind utf16_to_utf8_transcoder_core u16u8_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
